>>> src/itoa_pkg.sv
package itoa_pkg;

	// default sizes
	localparam int MAX_DIGITS_DEF = 20;
	localparam int VALUE_BITS_DEF = 64;

	// width of the two's complement word read in signed mode
	localparam int SIGNED_BITS = 32;

	// character codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// request type codes
	localparam logic REQ_UNSIGNED = 1'b0;
	localparam logic REQ_SIGNED   = 1'b1;

	typedef logic [3:0] digit_t;

	// control shared by every digit cell
	typedef struct packed {
		logic load;
		logic conv;
		logic emit;
	} cell_ctl_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_SIGN  = 5'b00100,
		ST_DIGIT = 5'b01000,
		ST_TERM  = 5'b10000
	} state_t;

endpackage

>>> src/itoa_cell.sv
module itoa_cell import itoa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      bit_in,
	input  digit_t    digit_in,
	output logic      bit_out,
	output digit_t    digit_out
);

	digit_t digit_q;
	digit_t adj;

	// add-three correction before the doubling shift
	always_comb begin
		adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	end

	assign bit_out   = adj[3];
	assign digit_out = digit_q;

	// clear on load, double and add bit while converting, pass digit up while emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.load) begin
			digit_q <= '0;
		end else if (ctl.conv) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.emit) begin
			digit_q <= digit_in;
		end
	end

endmodule

>>> src/integer_to_decimal_ascii.sv
// Sequence: ST_CONV shifts in one input bit per step (32 bits in signed mode, VALUE_BITS
// unsigned), ST_SIGN issues a minus sign for a negative value, ST_DIGIT walks MAX_DIGITS
// digit positions and ST_TERM issues the NUL. Busy holds from acceptance to ST_TERM,
// so a new value is taken only after the previous one is done; characters appear
// one register later. The rate is set by the one-bit-per-cycle shift through the digit
// cells. The receiver cannot stall. Reset clears the sequencer, cells and output strobe.
module integer_to_decimal_ascii import itoa_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [63:0] value,
	output logic        valid,
	output logic [7:0]  character,
	output logic        last
);

	localparam int BCW       = $clog2(VALUE_BITS + 1);
	localparam int DCW       = $clog2(MAX_DIGITS + 1);
	localparam int SGN_SHIFT = VALUE_BITS - SIGNED_BITS;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   shift_q;
	logic [BCW-1:0]          bcnt_q;
	logic [DCW-1:0]          dcnt_q;
	logic                    neg_q;
	logic                    seen_q;
	logic                    valid_q;
	logic [7:0]              char_q;
	logic                    last_q;

	logic                    accept;
	cell_ctl_t               ctl;
	logic [MAX_DIGITS:0]     carry;
	digit_t                  dig [MAX_DIGITS+1];
	digit_t                  top_digit;
	logic [SIGNED_BITS-1:0]  lo;
	logic                    lo_neg;
	logic [SIGNED_BITS-1:0]  mag32;
	logic [VALUE_BITS-1:0]   shift_load;
	logic                    skip;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// magnitude of the incoming value, left aligned in the shift register
	always_comb begin
		lo     = value[SIGNED_BITS-1:0];
		lo_neg = (req_type == REQ_SIGNED) && lo[SIGNED_BITS-1];
		mag32  = lo_neg ? (~lo + 1'b1) : lo;
		if (req_type == REQ_SIGNED) begin
			shift_load = VALUE_BITS'(mag32) << SGN_SHIFT;
		end else begin
			shift_load = value[VALUE_BITS-1:0];
		end
	end

	// cell control
	always_comb begin
		ctl.load = accept;
		ctl.conv = (state_q == ST_CONV);
		ctl.emit = (state_q == ST_DIGIT);
	end

	// chain of digit cells, least significant at index 0
	assign carry[0] = shift_q[VALUE_BITS-1];
	assign dig[0]   = '0;

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		itoa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.bit_in   (carry[i]),
			.digit_in (dig[i]),
			.bit_out  (carry[i+1]),
			.digit_out(dig[i+1])
		);
	end

	assign top_digit = dig[MAX_DIGITS];

	// leading zeros are dropped unless the value overflowed the digit row
	assign skip = (top_digit == 4'd0) && !seen_q && (dcnt_q > DCW'(1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			shift_q <= '0;
			bcnt_q  <= '0;
			dcnt_q  <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						shift_q <= shift_load;
						bcnt_q  <= (req_type == REQ_SIGNED) ? BCW'(SIGNED_BITS)
								: BCW'(VALUE_BITS);
						neg_q   <= lo_neg;
						seen_q  <= 1'b0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					shift_q <= shift_q << 1;
					bcnt_q  <= bcnt_q - 1'b1;
					if (carry[MAX_DIGITS]) begin
						seen_q <= 1'b1;
					end
					if (bcnt_q == BCW'(1)) begin
						dcnt_q  <= DCW'(MAX_DIGITS);
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					state_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (!skip) begin
						seen_q <= 1'b1;
					end
					if (dcnt_q == DCW'(1)) begin
						state_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			char_q  <= CHAR_NUL;
			last_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			case (state_q)
				ST_SIGN: begin
					valid_q <= 1'b1;
					char_q  <= CHAR_MINUS;
				end
				ST_DIGIT: begin
					if (!skip) begin
						valid_q <= 1'b1;
						char_q  <= CHAR_ZERO + {4'b0000, top_digit};
					end
				end
				ST_TERM: begin
					valid_q <= 1'b1;
					char_q  <= CHAR_NUL;
					last_q  <= 1'b1;
				end
				default: begin
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign valid     = valid_q;
	assign character = char_q;
	assign last      = last_q;

	// an item only comes out of a busy conversion
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("item strobed without a conversion in progress");

	// an accepted item starts a conversion
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not start a conversion");

	// the closing item is a strobed NUL
	a_last_nul: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> (valid && character == CHAR_NUL))
		else $error("last flag on something other than a NUL item");

	// every other item is a digit or a minus sign
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> (character == CHAR_MINUS ||
			(character >= CHAR_ZERO && character <= CHAR_NINE)))
		else $error("unexpected character");

	// the sequencer is already idle while the NUL is shown
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> !busy)
		else $error("still busy after the closing item");

endmodule
